// File: hdl/ntc_pkg.sv
package ntc_pkg;

    // Widths of the words on the two channels.
    localparam int ADC_W  = 16;
    localparam int TEMP_W = 17;

    // Calibration curve: divider readings at -40 C, -35 C, ... 125 C.
    localparam int TABLE_LEN    = 34;
    localparam int LAST_SEG     = TABLE_LEN - 1;
    localparam int SEG_W        = $clog2(TABLE_LEN);
    localparam int ZERO_C_INDEX = 8;

    typedef logic [SEG_W-1:0] seg_t;
    typedef logic [ADC_W-1:0] adc_t;
    typedef logic [TEMP_W-1:0] temp_t;

    localparam adc_t NTC_CURVE [0:TABLE_LEN-1] = '{
        16'hF825, 16'hF555, 16'hF1B4, 16'hED1C, 16'hE76A, 16'hE075, 16'hD830, 16'hCE4A,
        16'hC310, 16'hB6E0, 16'hA9C6, 16'h9C11, 16'h8E16, 16'h7FFF, 16'h7267, 16'h657E,
        16'h5976, 16'h4E82, 16'h449A, 16'h3BAB, 16'h33C9, 16'h2CEC, 16'h26F1, 16'h21BE,
        16'h1D40, 16'h195F, 16'h1608, 16'h1328, 16'h10AF, 16'h0E94, 16'h0CC4, 16'h0B32,
        16'h09D6, 16'h08AB
    };

endpackage

// File: hdl/ntc_if.sv
// Channel carrying one raw thermistor reading per word.
interface ntc_in_if
    import ntc_pkg::*;
();
    logic valid;
    logic ready;
    adc_t adc_value;

    modport source (output valid, output adc_value, input ready);
    modport sink (input valid, input adc_value, output ready);
endinterface

// Channel carrying one temperature result per word.
interface ntc_out_if
    import ntc_pkg::*;
();
    logic  valid;
    logic  ready;
    temp_t temp_q8;

    modport source (output valid, output temp_q8, input ready);
    modport sink (input valid, input temp_q8, output ready);
endinterface

// File: hdl/ntc_adc_to_celsius_interp.sv
// Converts one 16-bit NTC divider reading into degrees Celsius, signed two's
// complement with FRACTION_BITS fraction bits in a 17-bit word. A constant
// 34-point curve (one point per 5 degrees from -40 C to 125 C) is walked one
// entry per clock starting at segment 1, stopping at the first entry at or
// below the reading or at the last segment; readings past either end of the
// curve extrapolate along the end segment, and results that do not fit in 17
// bits saturate. The fraction within the segment comes from a restoring
// divider that produces one quotient bit per clock, truncating toward zero.
// After a word is accepted, the conversion passes through the SEARCH, DIVIDE
// and FINISH states before the result is registered; FINISH holds while an
// earlier result is still unclaimed. The block takes a new reading once per
// conversion, on the cycle after a result has been registered. A finished
// result waits in the output register, so a new reading is accepted while
// the previous result is still held there.
module ntc_adc_to_celsius_interp
    import ntc_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    ntc_in_if.sink    adc_in,
    ntc_out_if.source temp_out
);

    // The numerator magnitude is |lo - adc| * 5 * 2^F: 16 + 3 + F bits.
    localparam int Q_W   = ADC_W + 3 + FRACTION_BITS;
    localparam int CNT_W = $clog2(Q_W + 1);
    // Segment offset times 5 times 2^F plus the fraction, with headroom.
    localparam int SUM_W = Q_W + 2;

    typedef enum logic [1:0] {
        IDLE,
        SEARCH,
        DIVIDE,
        FINISH
    } state_t;

    state_t             state_reg;
    adc_t               adc_reg;
    seg_t               seg_reg;
    adc_t               div_reg;
    adc_t               rem_reg;
    logic [Q_W-1:0]     num_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg;
    temp_t              temp_reg;
    logic               out_valid_reg;

    // Search and divider setup.
    adc_t               seg_hi;
    adc_t               seg_lo;
    logic               advance;
    logic [ADC_W:0]     diff;
    adc_t               mag;
    logic [Q_W-1:0]     num_setup;

    // One restoring divider step.
    logic [ADC_W:0]     shifted;
    logic [ADC_W:0]     trial;
    logic               fits;
    adc_t               rem_next;
    logic [Q_W-1:0]     num_next;

    // Final sum and saturation.
    logic [SUM_W-1:0]   seg_off;
    logic [SUM_W-1:0]   base;
    logic [SUM_W-1:0]   frac;
    logic [SUM_W-1:0]   sum;
    logic               sat_hi;
    logic               sat_lo;
    temp_t              temp_next;

    assign adc_in.ready   = (state_reg == IDLE);
    assign temp_out.valid = out_valid_reg;
    assign temp_out.temp_q8 = temp_reg;

    always_comb
    begin
        seg_hi    = NTC_CURVE[seg_reg - seg_t'(1)];
        seg_lo    = NTC_CURVE[seg_reg];
        advance   = (seg_reg < seg_t'(LAST_SEG)) && (adc_reg < seg_lo);
        diff      = {1'b0, seg_lo} - {1'b0, adc_reg};
        mag       = diff[ADC_W] ? adc_t'(-diff) : diff[ADC_W-1:0];
        // Times five as a shift and add, then scaled by the fraction bits.
        num_setup = (Q_W'({mag, 2'b00}) + Q_W'(mag)) << FRACTION_BITS;
    end

    always_comb
    begin
        shifted  = {rem_reg, num_reg[Q_W-1]};
        trial    = shifted - {1'b0, div_reg};
        fits     = !(shifted < {1'b0, div_reg});
        rem_next = fits ? trial[ADC_W-1:0] : shifted[ADC_W-1:0];
        num_next = {num_reg[Q_W-2:0], fits};
    end

    always_comb
    begin
        seg_off   = SUM_W'(seg_reg) - SUM_W'(ZERO_C_INDEX);
        base      = ((seg_off << 2) + seg_off) << FRACTION_BITS;
        frac      = neg_reg ? -SUM_W'(num_reg) : SUM_W'(num_reg);
        sum       = base + frac;
        // In range when all bits from the sign of a 17-bit word upward agree.
        sat_hi    = !sum[SUM_W-1] && (|sum[SUM_W-2:TEMP_W-1]);
        sat_lo    = sum[SUM_W-1] && !(&sum[SUM_W-2:TEMP_W-1]);
        temp_next = sat_hi ? {1'b0, {(TEMP_W-1){1'b1}}} :
                    sat_lo ? {1'b1, {(TEMP_W-1){1'b0}}} :
                    sum[TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In FINISH the valid flag is handled below, where a new result
            // may take the place of the one being claimed.
            if (out_valid_reg && temp_out.ready && state_reg != FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (adc_in.valid)
                    begin
                        adc_reg   <= adc_in.adc_value;
                        seg_reg   <= seg_t'(1);
                        state_reg <= SEARCH;
                    end
                end
                SEARCH:
                begin
                    if (advance)
                    begin
                        seg_reg <= seg_reg + seg_t'(1);
                    end
                    else
                    begin
                        div_reg   <= seg_hi - seg_lo;
                        rem_reg   <= '0;
                        num_reg   <= num_setup;
                        neg_reg   <= diff[ADC_W];
                        cnt_reg   <= CNT_W'(Q_W);
                        state_reg <= DIVIDE;
                    end
                end
                DIVIDE:
                begin
                    rem_reg <= rem_next;
                    num_reg <= num_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= FINISH;
                    end
                end
                FINISH:
                begin
                    // Wait here only while an earlier result is still unclaimed.
                    if (!out_valid_reg || temp_out.ready)
                    begin
                        temp_reg      <= temp_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // The segment index never leaves the curve while a conversion runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != IDLE |-> seg_reg >= seg_t'(1) && seg_reg <= seg_t'(LAST_SEG))
        else $error("segment index outside the curve");

    // The curve falls strictly, so the divisor is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIVIDE |-> div_reg != '0)
        else $error("zero divisor");

    // The partial remainder stays below the divisor through the division.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIVIDE |-> rem_reg < div_reg)
        else $error("partial remainder not below divisor");

endmodule
